// File: design/kpm_pkg.sv
// Package with shared types, constants and a helper function of the Karatsuba multiplier.
`timescale 1ns / 1ps
`default_nettype none
package kpm_pkg;

    localparam int MAX_COEFFS_DEF = 32;
    localparam int COEF_W         = 16;
    localparam int PROD_W         = 32;
    localparam int OUT_W          = 37;
    localparam int LEN_W          = 6;
    localparam int K_W            = 6;
    localparam int CNT_W          = 7;

    // One finished load, handed from the front to the back.
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_READ,
        B_MUL,
        B_ACC,
        B_EMIT
    } back_state_t;

    // Number of product coefficients for a load of len pairs.
    function automatic logic [CNT_W-1:0] result_count(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] n;
        n = CNT_W'(1);
        for (int s = 0; s < LEN_W; s++) begin
            if (n < {1'b0, len})
            begin
                n = n << 1;
            end
        end
        if (n == CNT_W'(1))
        begin
            result_count = CNT_W'(1);
        end
        else
        begin
            result_count = n << 1;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/kpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/kpm_front.sv
// Load side: writes coefficient pairs into the current bank and closes a job on the last pair.
`timescale 1ns / 1ps
`default_nettype none
module kpm_front #(
    parameter int MAX_COEFFS = kpm_pkg::MAX_COEFFS_DEF,
    parameter int AW         = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          last_pair,
    output logic                               we,
    output logic [AW:0]                        waddr,
    output logic                               job_push,
    output kpm_pkg::job_t                      job
);

    logic [kpm_pkg::LEN_W-1:0] count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic                      bank_reg, bank_next;
    logic                      has_room;

    assign has_room = (count_reg < kpm_pkg::LEN_W'(MAX_COEFFS));
    assign we       = accept && has_room;
    assign waddr    = {bank_reg, count_reg[AW-1:0]};
    assign job_push = accept && last_pair;

    always_comb
    begin
        job.bank = bank_reg;
        job.len  = has_room ? count_reg + kpm_pkg::LEN_W'(1) : count_reg;
        job.ovf  = ovf_reg || !has_room;
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (last_pair)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                bank_next  = !bank_reg;
            end
            else if (has_room)
            begin
                count_next = count_reg + kpm_pkg::LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
        end
    end

endmodule
`default_nettype wire

// File: design/kpm_job_q.sv
// Two-entry job queue between the load side and the compute side.
`timescale 1ns / 1ps
`default_nettype none
module kpm_job_q (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire kpm_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output kpm_pkg::job_t      head_job
);

    kpm_pkg::job_t entry_reg [2];
    logic          head_reg, head_next;
    logic [1:0]    count_reg, count_next;
    logic          wr_ptr;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = entry_reg[head_reg];
    assign wr_ptr     = head_reg ^ count_reg[0];

    always_comb
    begin
        head_next  = pop ? !head_reg : head_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: design/kpm_back.sv
// Compute side: forms each product coefficient as a sum of products and holds it for transfer.
`timescale 1ns / 1ps
`default_nettype none
module kpm_back #(
    parameter int AW = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    input  wire kpm_pkg::job_t                 job,
    output logic                               job_pop,
    output logic [AW:0]                        raddr_a,
    output logic [AW:0]                        raddr_b,
    input  wire logic [kpm_pkg::COEF_W-1:0]    rdata_a,
    input  wire logic [kpm_pkg::COEF_W-1:0]    rdata_b,
    input  wire logic                          pop,
    output logic                               empty,
    output logic signed [kpm_pkg::OUT_W-1:0]   coef_out,
    output logic                               last_out,
    output logic                               overflow
);

    kpm_pkg::back_state_t state_reg, state_next;
    logic [kpm_pkg::K_W-1:0]          k_reg, k_next;
    logic [AW-1:0]                    i_reg, i_next, hi_reg, hi_next;
    logic signed [kpm_pkg::OUT_W-1:0] acc_reg, acc_next;
    logic signed [kpm_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [kpm_pkg::OUT_W-1:0] out_coef_reg, out_coef_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_ovf_reg, out_ovf_next;

    logic [kpm_pkg::CNT_W-1:0] count;
    logic [kpm_pkg::K_W-1:0]   last_k;
    logic [kpm_pkg::CNT_W-1:0] k7, l7, lo7, hi7, kb7;
    logic                      no_terms, slot_free, is_last;

    assign count     = kpm_pkg::result_count(job.len);
    assign last_k    = kpm_pkg::K_W'(count - kpm_pkg::CNT_W'(1));
    assign k7        = {1'b0, k_reg};
    assign l7        = {1'b0, job.len};
    assign lo7       = (k7 >= l7) ? k7 - l7 + kpm_pkg::CNT_W'(1) : '0;
    assign hi7       = (k7 < l7) ? k7 : l7 - kpm_pkg::CNT_W'(1);
    assign no_terms  = (k7 + kpm_pkg::CNT_W'(1)) >= (l7 << 1);
    assign kb7       = k7 - kpm_pkg::CNT_W'(i_reg);
    assign slot_free = !out_valid_reg || pop;
    assign is_last   = (k_reg == last_k);

    assign raddr_a = {job.bank, i_reg};
    assign raddr_b = {job.bank, kb7[AW-1:0]};

    assign empty    = !out_valid_reg;
    assign coef_out = out_coef_reg;
    assign last_out = out_last_reg;
    assign overflow = out_ovf_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kpm_pkg::B_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = kpm_pkg::B_START;
                end
            end
            kpm_pkg::B_START: state_next = no_terms ? kpm_pkg::B_EMIT : kpm_pkg::B_READ;
            kpm_pkg::B_READ:  state_next = kpm_pkg::B_MUL;
            kpm_pkg::B_MUL:   state_next = kpm_pkg::B_ACC;
            kpm_pkg::B_ACC:   state_next = (i_reg == hi_reg) ? kpm_pkg::B_EMIT : kpm_pkg::B_READ;
            kpm_pkg::B_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = is_last ? kpm_pkg::B_IDLE : kpm_pkg::B_START;
                end
            end
            default: state_next = kpm_pkg::B_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        k_next         = k_reg;
        i_next         = i_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !pop;
        out_coef_next  = out_coef_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        job_pop        = 1'b0;
        case (state_reg)
            kpm_pkg::B_IDLE:
            begin
                k_next = '0;
            end
            kpm_pkg::B_START:
            begin
                acc_next = '0;
                i_next   = lo7[AW-1:0];
                hi_next  = hi7[AW-1:0];
            end
            kpm_pkg::B_MUL:
            begin
                prod_next = $signed(rdata_a) * $signed(rdata_b);
            end
            kpm_pkg::B_ACC:
            begin
                acc_next = acc_reg + kpm_pkg::OUT_W'(prod_reg);
                i_next   = i_reg + AW'(1);
            end
            kpm_pkg::B_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_coef_next  = acc_reg;
                    out_last_next  = is_last;
                    out_ovf_next   = job.ovf;
                    k_next         = k_reg + kpm_pkg::K_W'(1);
                    job_pop        = is_last;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        i_reg        <= i_next;
        hi_reg       <= hi_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_coef_reg <= out_coef_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kpm_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: design/karatsuba_polynomial_multiply_top.sv
// Top level of the polynomial multiplier: load side, job queue, two coefficient RAMs, compute side.
`timescale 1ns / 1ps
`default_nettype none
// Coefficient pairs are pushed lowest degree first, one transfer per cycle while full is
// low; the pair with last_pair set closes a polynomial pair. Up to MAX_COEFFS pairs are
// kept; later pairs are dropped and every result of that product then has overflow set.
// The loaded length L is padded to the next power of two n and the block delivers 2n
// product coefficients (one when n is 1), lowest degree first, last_out on the final
// one; when n is above 1 the top coefficient is always zero. The product is exact, so it
// equals the Karatsuba result bit for bit. Loads go into one of two RAM banks while the
// compute side works on the other, so a new load streams in at full rate while an
// earlier product is being computed, with full raised only when two finished loads are
// waiting. The compute side uses one 16x16 multiplier and a 37-bit accumulator: once it
// has picked up a job, each coefficient goes through a setup state, a RAM read, a multiply
// and an accumulate step for each contributing term, and a state that places it in the
// output register when that register is free. The output register lets one result wait
// for pop while the next is built.
module karatsuba_polynomial_multiply_top #(
    parameter int MAX_COEFFS = kpm_pkg::MAX_COEFFS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic signed [kpm_pkg::COEF_W-1:0] coef_a,
    input  wire logic signed [kpm_pkg::COEF_W-1:0] coef_b,
    input  wire logic                              last_pair,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [kpm_pkg::OUT_W-1:0]       coef_out,
    output logic                                   last_out,
    output logic                                   overflow
);

    // Per-bank index width; one extra address bit selects the bank.
    localparam int AW    = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int DEPTH = 2 << AW;

    logic          accept;
    logic          we;
    logic [AW:0]   waddr, raddr_a, raddr_b;
    logic [kpm_pkg::COEF_W-1:0] rdata_a, rdata_b;
    logic          job_push, job_pop, job_valid;
    kpm_pkg::job_t new_job, head_job;

    // A pair transfers whenever push is high and the job queue has room.
    assign accept = push && !full;

    kpm_front #(
        .MAX_COEFFS (MAX_COEFFS),
        .AW         (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .last_pair (last_pair),
        .we        (we),
        .waddr     (waddr),
        .job_push  (job_push),
        .job       (new_job)
    );

    kpm_ram #(
        .WIDTH (kpm_pkg::COEF_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (coef_a),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    kpm_ram #(
        .WIDTH (kpm_pkg::COEF_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (coef_b),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // A job stays at the head until its last coefficient is placed in the output register,
    // which keeps its bank from being reloaded while it is still read.
    kpm_job_q u_job_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (new_job),
        .pop        (job_pop),
        .full       (full),
        .head_valid (job_valid),
        .head_job   (head_job)
    );

    kpm_back #(
        .AW (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (head_job),
        .job_pop   (job_pop),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .pop       (pop),
        .empty     (empty),
        .coef_out  (coef_out),
        .last_out  (last_out),
        .overflow  (overflow)
    );

endmodule
`default_nettype wire

// File: design/kpm_checker.sv
// Port-level checker for the polynomial multiplier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kpm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              full,
    input wire logic                              empty,
    input wire logic                              pop,
    input wire logic signed [kpm_pkg::OUT_W-1:0]  coef_out,
    input wire logic                              last_out,
    input wire logic                              overflow
);

    logic       mid_reg;
    logic       ovf_reg;
    logic [6:0] n_reg;
    logic       out_xfer;

    assign out_xfer = pop && !empty;

    // Track the overflow flag and result count of the product in transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= 1'b0;
            ovf_reg <= 1'b0;
            n_reg   <= '0;
        end
        else if (out_xfer)
        begin
            mid_reg <= !last_out;
            ovf_reg <= overflow;
            n_reg   <= last_out ? 7'd0 : n_reg + 7'd1;
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not idle in reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(coef_out) && $stable(last_out)
                              && $stable(overflow)))
        else $error("waiting result changed");

    a_ovf_same: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && mid_reg) |-> (overflow == ovf_reg))
        else $error("overflow flag changed within one product");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !last_out) |-> (n_reg < 7'd63))
        else $error("product longer than 64 results");

endmodule

bind karatsuba_polynomial_multiply_top kpm_checker u_kpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .coef_out (coef_out),
    .last_out (last_out),
    .overflow (overflow)
);
`default_nettype wire
